// ===== sv/mie_pkg.sv =====
package mie_pkg;

    localparam int BUF_BYTES = 11;
    localparam int BUF_W     = BUF_BYTES * 8;
    localparam int CNT_W     = 4;

    localparam logic [7:0]  CHAR_I       = 8'h69;  // 'i'
    localparam logic [7:0]  CHAR_L       = 8'h6C;  // 'l'
    localparam logic [7:0]  CHAR_PLUS    = 8'h2B;  // '+'
    localparam logic [7:0]  CHAR_MINUS   = 8'h2D;  // '-'
    localparam logic [7:0]  COMPACT_BIAS = 8'd5;
    localparam logic [63:0] COMPACT_MAX  = 64'd122;
    localparam logic [63:0] SMALL_LIMIT  = 64'h0000_0000_4000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic shift;
    } cmd_t;

    typedef struct packed {
        logic last_byte;
    } status_t;

endpackage

// ===== sv/mie_ctrl.sv =====
module mie_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mie_pkg::status_t status,
    output mie_pkg::cmd_t    cmd
);
    import mie_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.load   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.shift = 1'b1;
                    if (status.last_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/mie_datapath.sv =====
module mie_datapath (
    input  logic               clk,
    input  mie_pkg::cmd_t      cmd,
    input  logic               op,
    input  logic signed [63:0] value,
    output mie_pkg::status_t   status,
    output logic [7:0]         out_byte,
    output logic               last
);
    import mie_pkg::*;

    logic              op_reg;
    logic [63:0]       value_reg;
    logic [BUF_W-1:0]  buf_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              neg;
    logic [63:0]       mag;
    logic              single;
    logic              fixnum_range;
    logic [7:0]        single_byte;
    logic [7:0]        sb;
    logic [7:0]        fill;
    logic [3:0]        k;
    logic [7:0]        tag;
    logic [2:0]        limbs;
    logic [7:0]        h0;
    logic [7:0]        h1;
    logic [7:0]        h2;
    logic [1:0]        hcnt;
    logic [CNT_W-1:0]  pcnt;
    logic [63:0]       payload;
    logic [BUF_W-1:0]  buf_next;

    always_comb
    begin
        neg    = value_reg[63];
        mag    = neg ? (64'd0 - value_reg) : value_reg;
        single = (value_reg == 64'd0) || (mag <= COMPACT_MAX);
        fixnum_range = neg ? (mag <= SMALL_LIMIT) : (mag < SMALL_LIMIT);
        sb     = (value_reg == 64'd0) ? 8'd0 : (mag[7:0] + COMPACT_BIAS);
        single_byte = neg ? (8'd0 - sb) : sb;
        fill   = neg ? 8'hFF : 8'h00;

        // byte count of the compact form: highest byte that is not sign fill
        k = 4'd1;
        for (int i = 1; i < 8; i++)
        begin
            if (value_reg[i*8 +: 8] != fill)
            begin
                k = 4'(i + 1);
            end
        end
        tag = neg ? (8'd0 - {4'd0, k}) : {4'd0, k};

        limbs = 3'd1;
        for (int j = 1; j < 4; j++)
        begin
            if (mag[j*16 +: 16] != 16'd0)
            begin
                limbs = 3'(j + 1);
            end
        end

        h2 = 8'd0;
        if (op_reg || fixnum_range)
        begin
            if (single)
            begin
                pcnt    = '0;
                payload = '0;
                if (op_reg)
                begin
                    hcnt = 2'd1;
                    h0   = single_byte;
                    h1   = 8'd0;
                end
                else
                begin
                    hcnt = 2'd2;
                    h0   = CHAR_I;
                    h1   = single_byte;
                end
            end
            else
            begin
                pcnt    = k;
                payload = value_reg;
                if (op_reg)
                begin
                    hcnt = 2'd1;
                    h0   = tag;
                    h1   = 8'd0;
                end
                else
                begin
                    hcnt = 2'd2;
                    h0   = CHAR_I;
                    h1   = tag;
                end
            end
        end
        else
        begin
            // bignum: 'l', sign, limb count, limbs of the magnitude
            hcnt    = 2'd3;
            h0      = CHAR_L;
            h1      = neg ? CHAR_MINUS : CHAR_PLUS;
            h2      = {5'd0, limbs} + COMPACT_BIAS;
            pcnt    = {limbs, 1'b0};
            payload = mag;
        end

        case (hcnt)
            2'd1:    buf_next = {16'd0, payload, h0};
            2'd2:    buf_next = {8'd0, payload, h1, h0};
            default: buf_next = {payload, h2, h1, h0};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
        if (cmd.load)
        begin
            buf_reg <= buf_next;
            cnt_reg <= {2'd0, hcnt} + pcnt;
        end
        else if (cmd.shift)
        begin
            buf_reg <= {8'd0, buf_reg[BUF_W-1:8]};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign out_byte         = buf_reg[7:0];
    assign last             = (cnt_reg == CNT_W'(1));
    assign status.last_byte = last;

endmodule

// ===== sv/marshal_integer_encoder.sv =====
// The input transaction captures the operands, the calc state loads the output
// shift register, then the emit state presents n = 1..11 output bytes; the
// shift register emits one byte per cycle while out_ready is high, one item in flight.
// Reset: rst_n asynchronous, active low; clears the controller to idle.
// Datapath registers are not reset.
module marshal_integer_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [63:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               last
);
    import mie_pkg::*;

    cmd_t    cmd;
    status_t status;

    mie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mie_datapath u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .op       (op),
        .value    (value),
        .status   (status),
        .out_byte (out_byte),
        .last     (last)
    );

`ifndef SYNTHESIS
    a_calc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!out_valid && !in_ready))
        else $error("output valid or input ready right after input transaction");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> (in_ready && !out_valid))
        else $error("not idle after last byte");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while output valid");
`endif

endmodule
